@@ rtl/core/ogfd_pkg.sv @@
// ----------------------------------------------------------------------------
// ogfd_pkg
// Shared types and constants of the occupancy grid frontier detector.
// ----------------------------------------------------------------------------
`default_nettype none

package ogfd_pkg;

    // Grid limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4095;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);
    localparam int MIN_DIM    = 3;

    // Configuration port
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    // Cell classes: bit 0 = free, bit 1 = candidate
    localparam logic [1:0] CLS_NONE = 2'b00;
    localparam logic [1:0] CLS_FREE = 2'b01;
    localparam logic [1:0] CLS_CAND = 2'b10;
    localparam logic [7:0] CAND_MAX = 8'd50;

    // 3x3 window of classes, newest column in the low bits
    localparam int          WIN_W           = 18;
    localparam int          CENTER_CAND_BIT = 9;
    localparam logic [WIN_W-1:0] NEIGH_FREE_MASK = 18'h15455;

    // Result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic             frame_done;
        logic             is_frontier;
        logic [ROW_W-1:0] cell_row;
        logic [COL_W-1:0] cell_col;
    } result_t;

    typedef struct packed {
        logic                      we;
        logic [CFG_IDX_W-1:0]      index;
        logic [CFG_DATA_W-1:0]     data;
    } cfg_write_t;

    // Front to queue: one result per transfer
    typedef struct packed {
        logic    valid;
        result_t data;
    } push_t;

    typedef struct packed {
        logic busy;
    } front_status_t;

    typedef struct packed {
        logic [QUEUE_AW:0] count;
    } queue_status_t;

endpackage

`default_nettype wire

@@ rtl/core/occupancy_grid_frontier_detect_core.sv @@
// ----------------------------------------------------------------------------
// occupancy_grid_frontier_detect_core
// Frontier cell detector for an occupancy grid streamed in raster order.
// ----------------------------------------------------------------------------
// The block takes one cell per clock, sustained, as long as the result queue
// (four entries) has room; the line store is read when a cell is transferred
// and written back in the cycle after at the same column, so one read and one
// write per clock keep that rate. A cell is judged one row and one column
// behind the stream, so a frontier result for (row-1, col-1) is pushed from
// the second stage into the result queue after the cell at (row, col) is taken.
// The last grid cell always yields a result with tlast set; tuser is 0 when
// that result is an end marker with zero coordinates. There is no clearing
// pass after reset. Any configuration write restarts the frame.
`default_nettype none

module occupancy_grid_frontier_detect_core
    import ogfd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] occupancy

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [23:0]                m_tdata,   // [9:0] cell_col, [21:10] cell_row
    output logic [0:0]                 m_tuser,   // [0] is_frontier
    output logic                       m_tlast    // frame_done
);

    cfg_write_t     cfg;
    push_t          push;
    front_status_t  front_stat;
    queue_status_t  queue_stat;
    result_t        head;
    logic           accept;
    logic [QUEUE_AW:0] pending;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // Room check covers the cell still in the second stage
    assign pending  = queue_stat.count + (QUEUE_AW+1)'(front_stat.busy);
    assign s_tready = (pending < (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign accept   = s_tvalid && s_tready;

    ogfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .accept    (accept),
        .occupancy (s_tdata),
        .push      (push),
        .status    (front_stat)
    );

    ogfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (m_tready),
        .head       (head),
        .head_valid (m_tvalid),
        .status     (queue_stat)
    );

    assign m_tdata = {2'b00, head.cell_row, head.cell_col};
    assign m_tuser = head.is_frontier;
    assign m_tlast = head.frame_done;

    // Checks
    a_accept_enters_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> front_stat.busy)
        else $error("accepted cell did not reach the second stage");

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        queue_stat.count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> m_tlast)
        else $error("non-frontier result without frame end");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("end marker carries coordinates");

endmodule

`default_nettype wire

@@ rtl/core/ogfd_front.sv @@
// ----------------------------------------------------------------------------
// ogfd_front
// Accepts cells, classifies them, keeps the line store and the 3x3 window,
// and decides for each interior candidate whether it is a frontier cell.
// ----------------------------------------------------------------------------
`default_nettype none

module ogfd_front
    import ogfd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cfg_write_t    cfg,
    input  wire logic          accept,
    input  wire logic [7:0]    occupancy,
    output push_t              push,
    output front_status_t      status
);

    // Grid size, kept as last column / last row
    logic [COL_W-1:0] w_last_reg;
    logic [ROW_W-1:0] h_last_reg;

    // Position of the next incoming cell
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;

    // Line store: {upper, middle} class per column
    logic [3:0]       line_mem [MAX_WIDTH];
    logic [3:0]       line_rd_reg;

    // Second stage
    logic             b_valid_reg;
    logic [COL_W-1:0] b_col_reg;
    logic [ROW_W-1:0] b_row_reg;
    logic [1:0]       b_cls_reg;
    logic             b_last_reg;
    logic             b_test_reg;

    logic [WIN_W-1:0] win_reg;
    logic [WIN_W-1:0] win_next;

    logic [1:0]       cls;
    logic             is_last;
    logic             test_en;
    logic             frontier;
    logic [10:0]      w_clamp;
    logic [11:0]      h_clamp;

    // Classify the incoming cell
    always_comb
    begin
        if (occupancy == 8'd0)
        begin
            cls = CLS_FREE;
        end
        else if (occupancy <= CAND_MAX)
        begin
            cls = CLS_CAND;
        end
        else
        begin
            cls = CLS_NONE;
        end
    end

    assign is_last = (row_reg == h_last_reg) && (col_reg == w_last_reg);
    assign test_en = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));

    // Saturate written sizes to the supported range (width from data bits [10:0] only)
    always_comb
    begin
        w_clamp = cfg.data[10:0];
        if (w_clamp < 11'(MIN_DIM))
        begin
            w_clamp = 11'(MIN_DIM);
        end
        else if (w_clamp > 11'(MAX_WIDTH))
        begin
            w_clamp = 11'(MAX_WIDTH);
        end
        h_clamp = cfg.data[11:0];
        if (h_clamp < 12'(MIN_DIM))
        begin
            h_clamp = 12'(MIN_DIM);
        end
        else if (h_clamp > 12'(MAX_HEIGHT))
        begin
            h_clamp = 12'(MAX_HEIGHT);
        end
    end

    // Config registers and position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg <= COL_W'(MAX_WIDTH - 1);
            h_last_reg <= ROW_W'(1023);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg.we)
        begin
            unique case (cfg.index)
                REG_GRID_WIDTH:
                begin
                    w_last_reg <= COL_W'(w_clamp - 11'd1);
                end
                REG_GRID_HEIGHT:
                begin
                    h_last_reg <= ROW_W'(h_clamp - 12'd1);
                end
                default:
                begin
                end
            endcase
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (col_reg == w_last_reg)
            begin
                col_reg <= '0;
                row_reg <= is_last ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // Line store: read at accept, write back in the cycle after
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_rd_reg <= line_mem[col_reg];
        end
        if (b_valid_reg)
        begin
            line_mem[b_col_reg] <= {line_rd_reg[1:0], b_cls_reg};
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_col_reg  <= col_reg;
            b_row_reg  <= row_reg;
            b_cls_reg  <= cls;
            b_last_reg <= is_last;
            b_test_reg <= test_en;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= accept;
        end
    end

    // Window shift: new column = {current, middle, upper}
    assign win_next = {win_reg[WIN_W-7:0], b_cls_reg, line_rd_reg[1:0], line_rd_reg[3:2]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (cfg.we)
        begin
            win_reg <= '0;
        end
        else if (b_valid_reg)
        begin
            win_reg <= win_next;
        end
    end

    // Frontier test on the window center
    assign frontier = b_test_reg && win_next[CENTER_CAND_BIT] &&
                      ((win_next & NEIGH_FREE_MASK) != '0);

    always_comb
    begin
        push.valid            = b_valid_reg && (frontier || b_last_reg);
        push.data.frame_done  = b_last_reg;
        push.data.is_frontier = frontier;
        push.data.cell_col    = frontier ? b_col_reg - COL_W'(1) : '0;
        push.data.cell_row    = frontier ? b_row_reg - ROW_W'(1) : '0;
    end

    assign status.busy = b_valid_reg;

endmodule

`default_nettype wire

@@ rtl/core/ogfd_queue.sv @@
// ----------------------------------------------------------------------------
// ogfd_queue
// Short result queue; its head drives the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module ogfd_queue
    import ogfd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire push_t     push,
    input  wire logic      pop,
    output result_t        head,
    output logic           head_valid,
    output queue_status_t  status
);

    result_t              entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW:0]    count_reg;
    logic                 do_pop;

    assign head_valid   = (count_reg != '0);
    assign head         = entry_reg[rd_ptr_reg];
    assign do_pop       = pop && head_valid;
    assign status.count = count_reg;

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_ptr_reg] <= push.data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            if (push.valid && !do_pop)
            begin
                count_reg <= count_reg + (QUEUE_AW+1)'(1);
            end
            else if (!push.valid && do_pop)
            begin
                count_reg <= count_reg - (QUEUE_AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire
